@@ rtl/psu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Item types, filter type codes and configuration register indexes shared by
// the scanline unfilter modules.
// ----------------------------------------------------------------------------
package psu_pkg;

    // One input item: a byte of the inflated stream.
    typedef struct packed {
        logic [7:0] raw_byte;
        logic       image_start;
    } in_item_t;

    // One result item: a reconstructed byte or an error marker.
    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       image_end;
        logic       bad_filter;
    } out_item_t;

    // Filter type codes as declared at the head of each row.
    localparam logic [2:0] FILTER_NONE  = 3'd0;
    localparam logic [2:0] FILTER_SUB   = 3'd1;
    localparam logic [2:0] FILTER_UP    = 3'd2;
    localparam logic [2:0] FILTER_AVG   = 3'd3;
    localparam logic [2:0] FILTER_PAETH = 3'd4;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HAS_ALPHA    = 2'd2;

endpackage : psu_pkg
`default_nettype wire

@@ rtl/psu_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : psu_ram
`default_nettype wire

@@ rtl/psu_predict.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG byte predictor
// Adds the prediction of the row's filter type to a filtered byte: none, sub,
// up, average or Paeth, all modulo 256.
// ----------------------------------------------------------------------------
module psu_predict (
    input  wire logic [2:0] filter_type,
    input  wire logic [7:0] raw_byte,
    input  wire logic [7:0] left_byte,
    input  wire logic [7:0] above_byte,
    input  wire logic [7:0] corner_byte,
    output logic      [7:0] pixel_byte
);

    logic [8:0]        avg_sum;
    logic signed [9:0] dist_a;
    logic signed [9:0] dist_b;
    logic signed [9:0] dist_c;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    logic [7:0]        paeth;
    logic [7:0]        pred;

    assign avg_sum = {1'b0, left_byte} + {1'b0, above_byte};

    // Paeth distances: p - a = b - c, p - b = a - c, p - c = a + b - 2c.
    assign dist_a = $signed({2'b00, above_byte}) - $signed({2'b00, corner_byte});
    assign dist_b = $signed({2'b00, left_byte}) - $signed({2'b00, corner_byte});
    assign dist_c = dist_a + dist_b;
    assign pa = dist_a[9] ? 10'(-dist_a) : 10'(dist_a);
    assign pb = dist_b[9] ? 10'(-dist_b) : 10'(dist_b);
    assign pc = dist_c[9] ? 10'(-dist_c) : 10'(dist_c);

    // Ties go to left first, then above.
    always_comb begin
        if (pa <= pb && pa <= pc) begin
            paeth = left_byte;
        end else if (pb <= pc) begin
            paeth = above_byte;
        end else begin
            paeth = corner_byte;
        end
    end

    always_comb begin
        case (filter_type)
            psu_pkg::FILTER_SUB:   pred = left_byte;
            psu_pkg::FILTER_UP:    pred = above_byte;
            psu_pkg::FILTER_AVG:   pred = avg_sum[8:1];
            psu_pkg::FILTER_PAETH: pred = paeth;
            default:               pred = 8'd0;
        endcase
    end

    assign pixel_byte = raw_byte + pred;

endmodule : psu_predict
`default_nettype wire

@@ rtl/png_scanline_unfilter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Reconstructs 8-bit RGB or RGBA samples from an inflated PNG byte stream.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while the result register is free
// and gives one result per data byte. An accepted byte waits in the input
// stage until its result can be loaded into the result register. The first
// byte of each row is its filter type and yields no result. A filter type
// above four yields one error result, after which bytes are dropped until the
// next image start. The line store is a RAM of 4*MAX_WIDTH bytes with one
// read and one write port. The byte above is read at the edge that accepts
// the item, and the reconstructed byte is written back as the item leaves
// the input stage. The line store needs no clearing after reset; on the first
// row of every image the byte above is taken as zero. Configuration writes
// take effect at once and belong between images or while the block is idle.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 16384
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire psu_pkg::in_item_t                   s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output psu_pkg::out_item_t                       m_data,
    input  wire logic                                cfg_we,
    input  wire logic [psu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [psu_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int LINE_DEPTH = MAX_WIDTH * 4;
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int SW = $clog2(LINE_DEPTH + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Configuration registers.
    logic [12:0] image_width_reg;
    logic [14:0] image_height_reg;
    logic        has_alpha_reg;

    // Input stage.
    logic               s1_valid_reg;
    psu_pkg::in_item_t  s1_item_reg;

    // Row and pixel state.
    logic [AW-1:0] col_cnt_reg,  col_cnt_next;
    logic [RW-1:0] row_cnt_reg,  row_cnt_next;
    logic [2:0]    filter_reg,   filter_next;
    logic          await_reg,    await_next;
    logic          failed_reg,   failed_next;
    logic [31:0]   left_reg,     left_next;
    logic [31:0]   corner_reg,   corner_next;

    // Result register.
    logic               m_valid_reg;
    psu_pkg::out_item_t m_item_reg;
    psu_pkg::out_item_t out_item;
    logic               out_load;

    logic          out_free;
    logic          advance;
    logic          accept;
    logic [WW-1:0] wide;
    logic [HW-1:0] high;
    logic [SW-1:0] stride;
    logic [SW-1:0] stride_last;
    logic [AW-1:0] col;
    logic [AW-1:0] rd_addr;
    logic          first_pixel;
    logic [7:0]    above_q;
    logic [7:0]    left_byte;
    logic [7:0]    above_byte;
    logic [7:0]    corner_byte;
    logic [7:0]    value;
    logic          row_last;
    logic          img_last;
    logic          wr_en;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= 13'd1;
            image_height_reg <= 15'd1;
            has_alpha_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                psu_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[12:0];
                psu_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[14:0];
                psu_pkg::CFG_HAS_ALPHA:    has_alpha_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Saturated image geometry and the row length in bytes.
    assign wide = (image_width_reg == 13'd0) ? WW'(1) :
                  ((32'(image_width_reg) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH)
                                                          : WW'(image_width_reg));
    assign high = (image_height_reg == 15'd0) ? HW'(1) :
                  ((32'(image_height_reg) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
                                                            : HW'(image_height_reg));
    assign stride = has_alpha_reg ? SW'({wide, 2'b00})
                                  : SW'({wide, 1'b0}) + SW'(wide);
    assign stride_last = stride - SW'(1);

    // Handshake: the input stage moves on whenever the result register is free.
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= s_data;
        end
    end

    // Column used for the line store, held at the row end after a width change.
    assign col = (SW'(col_cnt_reg) < stride) ? col_cnt_reg : AW'(stride_last);

    // Neighbor bytes: left and corner sit one pixel back in the shift registers.
    assign first_pixel = 32'(col) < (has_alpha_reg ? 32'd4 : 32'd3);
    assign above_byte  = (row_cnt_reg != '0) ? above_q : 8'd0;
    assign left_byte   = first_pixel ? 8'd0 :
                         (has_alpha_reg ? left_reg[31:24] : left_reg[23:16]);
    assign corner_byte = (first_pixel || row_cnt_reg == '0) ? 8'd0 :
                         (has_alpha_reg ? corner_reg[31:24] : corner_reg[23:16]);

    psu_predict u_predict (
        .filter_type (filter_reg),
        .raw_byte    (s1_item_reg.raw_byte),
        .left_byte   (left_byte),
        .above_byte  (above_byte),
        .corner_byte (corner_byte),
        .pixel_byte  (value)
    );

    assign row_last = (SW'(col_cnt_reg) + SW'(1)) >= stride;
    assign img_last = row_last && ((HW'(row_cnt_reg) + HW'(1)) >= high);

    // Next state for the item in the input stage.
    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        filter_next  = filter_reg;
        await_next   = await_reg;
        failed_next  = failed_reg;
        left_next    = left_reg;
        corner_next  = corner_reg;
        out_load     = 1'b0;
        out_item     = '0;
        wr_en        = 1'b0;
        if (advance) begin
            if (s1_item_reg.image_start) begin
                col_cnt_next = '0;
                row_cnt_next = '0;
                await_next   = 1'b1;
                failed_next  = 1'b0;
                left_next    = '0;
                corner_next  = '0;
            end
            if (!failed_next) begin
                if (await_next) begin
                    // Filter type byte of a new row.
                    if (s1_item_reg.raw_byte > 8'(psu_pkg::FILTER_PAETH)) begin
                        failed_next         = 1'b1;
                        out_load            = 1'b1;
                        out_item.bad_filter = 1'b1;
                    end else begin
                        filter_next  = s1_item_reg.raw_byte[2:0];
                        await_next   = 1'b0;
                        col_cnt_next = '0;
                        left_next    = '0;
                        corner_next  = '0;
                    end
                end else begin
                    // Data byte: deliver it and store it for the next row.
                    out_load            = 1'b1;
                    out_item.pixel_byte = value;
                    out_item.image_end  = img_last;
                    wr_en               = 1'b1;
                    left_next           = {left_reg[23:0], value};
                    corner_next         = {corner_reg[23:0], above_byte};
                    if (row_last) begin
                        col_cnt_next = '0;
                        await_next   = 1'b1;
                        row_cnt_next = img_last ? '0 : row_cnt_reg + RW'(1);
                    end else begin
                        col_cnt_next = col_cnt_reg + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            filter_reg  <= psu_pkg::FILTER_NONE;
            await_reg   <= 1'b1;
            failed_reg  <= 1'b0;
            left_reg    <= '0;
            corner_reg  <= '0;
        end else begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            filter_reg  <= filter_next;
            await_reg   <= await_next;
            failed_reg  <= failed_next;
            left_reg    <= left_next;
            corner_reg  <= corner_next;
        end
    end

    // The byte above the next item is read from the state this item leaves.
    assign rd_addr = (SW'(col_cnt_next) < stride) ? col_cnt_next : AW'(stride_last);

    psu_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (col),
        .wr_data (value),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (above_q)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= out_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_item_reg <= out_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_item_reg;

endmodule : png_scanline_unfilter
`default_nettype wire

@@ rtl/psu_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG scanline unfilter checker
// Port-level assertions on the item channels of the scanline unfilter.
// ----------------------------------------------------------------------------
module psu_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire psu_pkg::in_item_t  s_data,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire psu_pkg::out_item_t m_data
);

    // A stalled result item holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // The error item carries no sample and does not end the image.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_filter |-> m_data.pixel_byte == 8'd0 && !m_data.image_end)
        else $error("error item carries data");

    // A new result comes from an accepted item that passed through the input stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result item without an accepted input item");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The input side is never blocked by an empty result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !s_ready |=> s_ready)
        else $error("input held off with no result waiting");

endmodule : psu_checker

bind png_scanline_unfilter psu_checker u_psu_checker (.*);
`default_nettype wire

@@ bench/png_scanline_unfilter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter testbench
// Streams filter bytes and filtered samples into the unfilter and checks every
// reconstructed byte against an in-bench model of the five PNG filters. The
// model keeps its own line store and pixel history. Directed images, register
// limits, output back-pressure and a long random stream of well-formed and
// broken images are run in turn.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_tb;

    localparam int MAX_W = 4096;
    localparam int MAX_H = 16384;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    psu_pkg::in_item_t  s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    psu_pkg::out_item_t m_data;
    logic               cfg_we    = 1'b0;
    logic [psu_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // Shared controls for idling and the long output stall, and the mismatch count.
    bit idle_on    = 1'b1;
    int sink_hold  = 0;
    int mismatches = 0;

    // Bench copy of the configuration registers.
    logic [12:0] reg_width  = 13'd1;
    logic [14:0] reg_height = 15'd1;
    logic        reg_alpha  = 1'b0;

    // Bench copy of the unfilter state.
    logic [7:0]  line_mem [0:4*MAX_W-1];
    logic [31:0] left_q      = '0;
    logic [31:0] corner_q    = '0;
    int unsigned col_n       = 0;
    int unsigned row_n       = 0;
    logic [2:0]  cur_filter  = psu_pkg::FILTER_NONE;
    bit          want_filter = 1'b1;
    bit          dead        = 1'b0;

    // Reconstructed bytes that the block still owes.
    psu_pkg::out_item_t pending_px [$];

    png_scanline_unfilter #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Bytes per row and rows per image, with the registers saturated.
    function automatic int unsigned row_bytes();
        int unsigned wide;
        wide = (reg_width == 0) ? 1 : ((reg_width > MAX_W) ? MAX_W : reg_width);
        return wide * (reg_alpha ? 4 : 3);
    endfunction

    function automatic int unsigned image_rows();
        return (reg_height == 0) ? 1 : ((reg_height > MAX_H) ? MAX_H : reg_height);
    endfunction

    function automatic logic [7:0] paeth_select(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c);
        int p, pa, pb, pc;
        p  = int'(a) + int'(b) - int'(c);
        pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
        pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
        pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
        if (pa <= pb && pa <= pc)
            return a;
        return (pb <= pc) ? b : c;
    endfunction

    // Advances the bench state by one accepted item and queues its result, if any.
    function automatic void unfilter_byte(input psu_pkg::in_item_t item);
        int unsigned        chans, stride, col, shift;
        logic [7:0]         left_b, above_b, corner_b, value;
        logic [8:0]         avg;
        bit                 row_last, img_last;
        psu_pkg::out_item_t res;
        chans  = reg_alpha ? 4 : 3;
        stride = row_bytes();
        if (item.image_start) begin
            col_n       = 0;
            row_n       = 0;
            want_filter = 1'b1;
            dead        = 1'b0;
            left_q      = '0;
            corner_q    = '0;
        end
        if (dead)
            return;

        // The first byte of a row selects the filter.
        if (want_filter) begin
            if (item.raw_byte > 8'(psu_pkg::FILTER_PAETH)) begin
                dead           = 1'b1;
                res.pixel_byte = 8'h00;
                res.image_end  = 1'b0;
                res.bad_filter = 1'b1;
                pending_px.push_back(res);
                return;
            end
            cur_filter  = item.raw_byte[2:0];
            want_filter = 1'b0;
            col_n       = 0;
            left_q      = '0;
            corner_q    = '0;
            return;
        end

        // Neighbors are zero off the left edge and above the first row.
        col      = (col_n < stride) ? col_n : stride - 1;
        shift    = 8 * (chans - 1);
        left_b   = (col >= chans) ? 8'(left_q >> shift) : 8'h00;
        above_b  = (row_n > 0) ? line_mem[col] : 8'h00;
        corner_b = (row_n > 0 && col >= chans) ? 8'(corner_q >> shift) : 8'h00;
        avg      = ({1'b0, left_b} + {1'b0, above_b}) >> 1;

        case (cur_filter)
            psu_pkg::FILTER_SUB:   value = item.raw_byte + left_b;
            psu_pkg::FILTER_UP:    value = item.raw_byte + above_b;
            psu_pkg::FILTER_AVG:   value = item.raw_byte + avg[7:0];
            psu_pkg::FILTER_PAETH: value = item.raw_byte +
                                           paeth_select(left_b, above_b, corner_b);
            default:               value = item.raw_byte;
        endcase

        line_mem[col] = value;
        left_q        = {left_q[23:0], value};
        corner_q      = {corner_q[23:0], above_b};
        row_last      = (col_n + 1 >= stride);
        img_last      = row_last && (row_n + 1 >= image_rows());
        if (row_last) begin
            col_n       = 0;
            want_filter = 1'b1;
            row_n       = img_last ? 0 : row_n + 1;
        end else begin
            col_n++;
        end

        res.pixel_byte = value;
        res.image_end  = img_last;
        res.bad_filter = 1'b0;
        pending_px.push_back(res);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Offers one item after a random gap, if idling, and holds it until taken.
    task automatic send_byte(input logic [7:0] raw, input bit start);
        int                gap;
        psu_pkg::in_item_t item;
        gap              = idle_on ? $urandom_range(0, 9) : 0;
        item.raw_byte    = raw;
        item.image_start = start;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        unfilter_byte(item);
    endtask

    task automatic send_row(input logic [2:0] filter, input bit start);
        send_byte({5'd0, filter}, start);
        repeat (row_bytes()) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic send_image(input bit start);
        for (int r = 0; r < image_rows(); r++)
            send_row(3'($urandom_range(0, 4)), start && r == 0);
    endtask

    // Stops offering items and waits until every owed result has come.
    task automatic settle();
        int waited;
        s_valid <= 1'b0;
        waited = 0;
        while (pending_px.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_px.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_px.size()));
            pending_px.delete();
        end
        repeat (8) @(posedge aclk);
    endtask

    // Writes all three registers on consecutive cycles; the block must be idle.
    task automatic configure(input int unsigned width_px, input int unsigned height_rows,
                             input bit alpha);
        cfg_we    <= 1'b1;
        cfg_index <= psu_pkg::CFG_IMAGE_WIDTH;
        cfg_data  <= psu_pkg::CFG_DATA_W'(width_px);
        @(posedge aclk);
        cfg_index <= psu_pkg::CFG_IMAGE_HEIGHT;
        cfg_data  <= psu_pkg::CFG_DATA_W'(height_rows);
        @(posedge aclk);
        cfg_index <= psu_pkg::CFG_HAS_ALPHA;
        cfg_data  <= psu_pkg::CFG_DATA_W'(alpha);
        @(posedge aclk);
        cfg_we     <= 1'b0;
        reg_width  = 13'(width_px);
        reg_height = 15'(height_rows);
        reg_alpha  = alpha;
    endtask

    // Every filter on a one-pixel image, a fresh image without a start flag,
    // and bad filter types with the bytes that follow them dropped.
    task automatic test_directed_filters();
        settle();
        configure(1, 3, 1'b0);
        send_byte(8'(psu_pkg::FILTER_PAETH), 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'(psu_pkg::FILTER_UP), 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'(psu_pkg::FILTER_AVG), 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hfe, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'(psu_pkg::FILTER_SUB), 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'(psu_pkg::FILTER_NONE), 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h5a, 1'b0);
        send_byte(8'h05, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h07, 1'b1);
    endtask

    // Zero and oversized register values saturate to the legal range. The
    // oversized width runs only the head of one row to keep the item count low.
    task automatic test_register_limits();
        settle();
        configure(0, 0, 1'b1);
        send_image(1'b1);
        settle();
        configure(8191, 2, 1'b0);
        send_byte(8'(psu_pkg::FILTER_PAETH), 1'b1);
        repeat (48) send_byte(8'($urandom), 1'b0);
        settle();
        configure(1, MAX_H, 1'b1);
        send_row(psu_pkg::FILTER_PAETH, 1'b1);
        send_row(psu_pkg::FILTER_AVG, 1'b0);
        settle();
        configure(1, 32767, 1'b0);
        send_row(psu_pkg::FILTER_SUB, 1'b1);
        send_row(psu_pkg::FILTER_UP, 1'b0);
    endtask

    // The receiver stalls for a long stretch while items keep coming.
    task automatic test_backpressure();
        settle();
        configure(4, 3, 1'b1);
        idle_on   = 1'b0;
        sink_hold = 200;
        send_image(1'b1);
        settle();
        idle_on = 1'b1;
    endtask

    // Mostly well-formed images with random content, plus bad filter types
    // and images cut short by the next image start.
    task automatic test_random_stream();
        int unsigned counted, budget, phase, kind, n;
        bit          need_start;
        counted = 0;
        phase   = 0;
        while (counted < 1100) begin
            settle();
            idle_on = (phase % 4 != 3);
            if ($urandom_range(0, 9) == 0)
                configure($urandom_range(9, 64), $urandom_range(1, 4),
                          1'($urandom_range(0, 1)));
            else
                configure($urandom_range(1, 8), $urandom_range(1, 4),
                          1'($urandom_range(0, 1)));
            need_start = 1'b1;
            budget     = counted + $urandom_range(80, 200);
            while (counted < budget) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    send_byte(8'($urandom_range(5, 255)), 1'b1);
                    repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
                    counted++;
                    need_start = 1'b1;
                end else if (kind == 1) begin
                    n = $urandom_range(0, 2 * row_bytes());
                    send_byte(8'($urandom_range(0, 4)), 1'b1);
                    repeat (n) send_byte(8'($urandom), 1'b0);
                    counted += n + 1;
                    need_start = 1'b1;
                end else begin
                    // A complete image may follow the last one with no start flag.
                    send_image(need_start || kind != 2);
                    counted += image_rows() * (row_bytes() + 1);
                    need_start = 1'b0;
                end
            end
            phase++;
        end
        idle_on = 1'b1;
    endtask

    // Receiver: a random wait before each item, plus the long stall on request.
    initial begin : result_sink
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold) @(posedge aclk);
                sink_hold = 0;
            end
            gap = idle_on ? $urandom_range(0, 9) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Each accepted result is matched against the oldest owed byte.
    always @(posedge aclk) begin : result_check
        psu_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_px.size() == 0) begin
                report_mismatch($sformatf("result with nothing owed: %p", m_data));
            end else begin
                want = pending_px.pop_front();
                if (m_data.pixel_byte !== want.pixel_byte)
                    report_mismatch($sformatf("pixel_byte %h, expected %h",
                                              m_data.pixel_byte, want.pixel_byte));
                if (m_data.image_end !== want.image_end)
                    report_mismatch($sformatf("image_end %b, expected %b",
                                              m_data.image_end, want.image_end));
                if (m_data.bad_filter !== want.bad_filter)
                    report_mismatch($sformatf("bad_filter %b, expected %b",
                                              m_data.bad_filter, want.bad_filter));
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_filters();
        test_register_limits();
        test_backpressure();
        test_random_stream();
        settle();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #(2_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
